[hw/rtl/quadrature_decoder_with_acceleration_core_assert.svh]
// assertion macros shared by the checker
`ifndef QUADRATURE_DECODER_WITH_ACCELERATION_CORE_ASSERT_SVH
`define QUADRATURE_DECODER_WITH_ACCELERATION_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define QDEC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define QDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/qdec_pkg.sv]
package qdec_pkg;

  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SCALE_W    = 10;
  localparam int MOVES_W    = 16;
  localparam int SPEED_W    = 16;
  localparam int POS_W      = 4;
  localparam int COUNT_W    = 4;
  localparam int THR_W      = 3;
  localparam int PROD_W     = MOVES_W + SCALE_W;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_DEBOUNCE_MS = 3'd0;
  localparam cfg_idx_t REG_WINDOW_MS   = 3'd1;
  localparam cfg_idx_t REG_SPEED_SCALE = 3'd2;
  localparam cfg_idx_t REG_SLOW_BELOW  = 3'd3;
  localparam cfg_idx_t REG_MID_BELOW   = 3'd4;
  localparam cfg_idx_t REG_FAST_BELOW  = 3'd5;

  // step multipliers
  localparam logic [COUNT_W-1:0] MULT_X1 = 4'd1;
  localparam logic [COUNT_W-1:0] MULT_X2 = 4'd2;
  localparam logic [COUNT_W-1:0] MULT_X4 = 4'd4;
  localparam logic [COUNT_W-1:0] MULT_X8 = 4'd8;

  // position thresholds that go with each multiplier
  localparam logic [THR_W-1:0] THR_X1 = 3'd4;
  localparam logic [THR_W-1:0] THR_X2 = 3'd2;
  localparam logic [THR_W-1:0] THR_X4 = 3'd1;
  localparam logic [THR_W-1:0] THR_X8 = 3'd1;

  // indexed by {previous lines, new lines}
  localparam logic signed [1:0] STEP_TABLE [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  typedef struct packed {
    logic [15:0]        debounce_ms;
    logic [15:0]        window_ms;
    logic [SCALE_W-1:0] speed_scale;
    logic [SPEED_W-1:0] slow_below;
    logic [SPEED_W-1:0] mid_below;
    logic [SPEED_W-1:0] fast_below;
  } qdec_cfg_t;

  typedef struct packed {
    logic              line_a;
    logic              line_b;
    logic [TIME_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic               emit;
    logic               direction_down;
    logic [COUNT_W-1:0] step_count;
  } step_res_t;

endpackage

[hw/rtl/qdec_if.sv]
interface qdec_sample_if
  import qdec_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              line_a;
  logic              line_b;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, line_a, line_b, now_ms, input ready);
  modport sink   (input valid, line_a, line_b, now_ms, output ready);
endinterface

interface qdec_step_if
  import qdec_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               direction_down;
  logic [COUNT_W-1:0] step_count;

  modport source (output valid, direction_down, step_count, input ready);
  modport sink   (input valid, direction_down, step_count, output ready);
endinterface

interface qdec_cfg_if
  import qdec_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/quadrature_decoder_with_acceleration_core.sv]
// a sample accepted into the sample register passes to the step register once the step slot is free
// throughput: one sample per clock unless the step channel stalls, whether or not it yields an event
// the step channel is registered; a stalled step holds only the sample stage
// reset (rst_ni low, asynchronous): registers back to defaults, all decode
// state and both pipeline stages cleared, no transaction pending
module quadrature_decoder_with_acceleration_core
  import qdec_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  qdec_sample_if.sink  sample_i,
  qdec_step_if.source  step_o,
  qdec_cfg_if.sink     cfg_i
);

  // configuration registers, always ready for a write
  qdec_cfg_t cfg;

  assign cfg_i.ready = 1'b1;

  qdec_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  // sample register: holds the item the decode logic works on this cycle
  sample_t   sample_q;
  logic      sample_valid_q, sample_valid_d;

  // step register: result waiting on the output channel
  step_res_t res;
  logic      step_valid_q, step_valid_d;
  logic      step_dir_q;
  logic [COUNT_W-1:0] step_count_q;

  logic      sample_acc;
  logic      slot_free;
  logic      advance;

  // the step slot is free when empty or emptied at this edge
  assign slot_free  = !step_valid_q || step_o.ready;
  // the held sample commits its state update and its event together
  assign advance    = sample_valid_q && slot_free;
  // a new sample enters whenever the sample stage empties at this edge
  assign sample_i.ready = !sample_valid_q || advance;
  assign sample_acc = sample_i.valid && sample_i.ready;

  always_comb begin
    sample_valid_d = sample_valid_q;
    if (sample_acc) begin
      sample_valid_d = 1'b1;
    end else if (advance) begin
      sample_valid_d = 1'b0;
    end
  end

  always_comb begin
    step_valid_d = step_valid_q;
    if (advance) begin
      // samples that are unchanged, fall inside the debounce time or do not cross the threshold leave no event
      step_valid_d = res.emit;
    end else if (step_o.ready) begin
      step_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_valid_q <= 1'b0;
      step_valid_q   <= 1'b0;
    end else begin
      sample_valid_q <= sample_valid_d;
      step_valid_q   <= step_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      sample_q.line_a <= sample_i.line_a;
      sample_q.line_b <= sample_i.line_b;
      sample_q.now_ms <= sample_i.now_ms;
    end
    if (advance) begin
      step_dir_q   <= res.direction_down;
      step_count_q <= res.step_count;
    end
  end

  // debounce, transition decode, speed window and threshold test
  qdec_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .sample_i  (sample_q),
    .advance_i (advance),
    .res_o     (res)
  );

  assign step_o.valid          = step_valid_q;
  assign step_o.direction_down = step_dir_q;
  assign step_o.step_count     = step_count_q;

endmodule

[hw/rtl/qdec_cfg_regs.sv]
module qdec_cfg_regs
  import qdec_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  cfg_idx_t              wr_idx_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output qdec_cfg_t             cfg_o
);

  qdec_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        REG_DEBOUNCE_MS: cfg_d.debounce_ms = wr_data_i;
        REG_WINDOW_MS:   cfg_d.window_ms   = wr_data_i;
        REG_SPEED_SCALE: cfg_d.speed_scale = wr_data_i[SCALE_W-1:0];
        REG_SLOW_BELOW:  cfg_d.slow_below  = wr_data_i;
        REG_MID_BELOW:   cfg_d.mid_below   = wr_data_i;
        REG_FAST_BELOW:  cfg_d.fast_below  = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= 16'd2;
      cfg_q.window_ms   <= 16'd100;
      cfg_q.speed_scale <= 10'd10;
      cfg_q.slow_below  <= 16'd5;
      cfg_q.mid_below   <= 16'd15;
      cfg_q.fast_below  <= 16'd30;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/qdec_engine.sv]
module qdec_engine
  import qdec_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  qdec_cfg_t cfg_i,
  input  sample_t   sample_i,
  input  logic      advance_i,
  output step_res_t res_o
);

  logic [1:0]                last_lines_q;
  logic [TIME_W-1:0]         last_change_q;
  logic signed [POS_W-1:0]   position_q, position_d;
  logic [MOVES_W-1:0]        moves_q, moves_d;
  logic [TIME_W-1:0]         win_start_q;
  logic [SPEED_W-1:0]        speed_q;

  logic [1:0]                lines;
  logic                      changed;
  logic [TIME_W-1:0]         since_change;
  logic [TIME_W-1:0]         since_window;
  logic                      accepted;
  logic signed [1:0]         delta;
  logic signed [POS_W-1:0]   pos_sum;
  logic [MOVES_W-1:0]        moves_inc;
  logic                      refresh;
  logic [PROD_W-1:0]         prod;
  logic [SPEED_W-1:0]        prod_sat;
  logic [SPEED_W-1:0]        speed_new;
  logic [COUNT_W-1:0]        mult;
  logic [THR_W-1:0]          thr;
  logic signed [POS_W-1:0]   thr_s;
  logic                      hit_up;
  logic                      hit_down;

  always_comb begin
    lines        = {sample_i.line_a, sample_i.line_b};
    changed      = (lines != last_lines_q);
    since_change = sample_i.now_ms - last_change_q;
    accepted     = changed && (since_change >= {16'd0, cfg_i.debounce_ms});

    delta   = STEP_TABLE[{last_lines_q, lines}];
    pos_sum = position_q + {{(POS_W-2){delta[1]}}, delta};

    moves_inc = ((delta != 2'sd0) && (moves_q != '1)) ? moves_q + 16'd1 : moves_q;

    since_window = sample_i.now_ms - win_start_q;
    refresh      = (since_window >= {16'd0, cfg_i.window_ms});
    prod         = {{SCALE_W{1'b0}}, moves_inc} * {{MOVES_W{1'b0}}, cfg_i.speed_scale};
    prod_sat     = (|prod[PROD_W-1:SPEED_W]) ? '1 : prod[SPEED_W-1:0];
    speed_new    = refresh ? prod_sat : speed_q;

    if (speed_new < cfg_i.slow_below) begin
      mult = MULT_X1;
      thr  = THR_X1;
    end else if (speed_new < cfg_i.mid_below) begin
      mult = MULT_X2;
      thr  = THR_X2;
    end else if (speed_new < cfg_i.fast_below) begin
      mult = MULT_X4;
      thr  = THR_X4;
    end else begin
      mult = MULT_X8;
      thr  = THR_X8;
    end

    thr_s    = $signed({1'b0, thr});
    hit_up   = (pos_sum >= thr_s);
    hit_down = (pos_sum <= -thr_s);

    position_d = (hit_up || hit_down) ? '0 : pos_sum;
    moves_d    = refresh ? '0 : moves_inc;

    res_o.emit           = accepted && (hit_up || hit_down);
    res_o.direction_down = !hit_up;
    res_o.step_count     = mult;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_lines_q  <= '0;
      last_change_q <= '0;
      position_q    <= '0;
      moves_q       <= '0;
      win_start_q   <= '0;
      speed_q       <= '0;
    end else if (advance_i && accepted) begin
      last_lines_q  <= lines;
      last_change_q <= sample_i.now_ms;
      position_q    <= position_d;
      moves_q       <= moves_d;
      if (refresh) begin
        win_start_q <= sample_i.now_ms;
        speed_q     <= prod_sat;
      end
    end
  end

endmodule

[hw/rtl/qdec_checker.sv]
`include "quadrature_decoder_with_acceleration_core_assert.svh"

module qdec_checker
  import qdec_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               sample_valid_i,
  input logic               sample_ready_i,
  input logic               step_valid_i,
  input logic               step_ready_i,
  input logic               step_dir_i,
  input logic [COUNT_W-1:0] step_count_i
);

  // a stalled step transaction keeps its payload
  `QDEC_ASSERT_NEXT(a_step_hold, clk_i, rst_ni, step_valid_i && !step_ready_i, step_valid_i && $stable(step_dir_i) && $stable(step_count_i), "step changed while stalled")

  // step count is always 1, 2, 4 or 8
  `QDEC_ASSERT_NOW(a_step_onehot, clk_i, rst_ni, step_valid_i, $onehot(step_count_i), "step count not a power of two")

  // a fresh step comes from a sample accepted earlier through the sample register
  `QDEC_ASSERT_NOW(a_step_origin, clk_i, rst_ni, $rose(step_valid_i), $past(sample_valid_i && sample_ready_i, 2), "step without a sample")

endmodule

bind quadrature_decoder_with_acceleration_core qdec_checker u_qdec_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .sample_valid_i (sample_i.valid),
  .sample_ready_i (sample_i.ready),
  .step_valid_i   (step_o.valid),
  .step_ready_i   (step_o.ready),
  .step_dir_i     (step_o.direction_down),
  .step_count_i   (step_o.step_count)
);
